// ===== sv/ptrs_pkg.sv =====
`timescale 1ns / 1ps
package ptrs_pkg;

    localparam int DEF_RULE_SLOTS   = 16;
    localparam int DEF_METRIC_COUNT = 6;

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_DISABLE = 3'd1;
    localparam logic [2:0] CMD_WRITE   = 3'd2;
    localparam logic [2:0] CMD_READ    = 3'd3;
    localparam logic [2:0] CMD_EVAL    = 3'd4;

    localparam logic [2:0] CMP_LT = 3'd0;
    localparam logic [2:0] CMP_LE = 3'd1;
    localparam logic [2:0] CMP_GT = 3'd2;
    localparam logic [2:0] CMP_GE = 3'd3;
    localparam logic [2:0] CMP_EQ = 3'd4;
    localparam logic [2:0] CMP_NE = 3'd5;

    typedef struct packed {
        logic [31:0] priority_val;
        logic [31:0] threshold;
        logic [7:0]  target;
        logic [2:0]  comparator;
        logic [2:0]  metric;
    } rule_ent_t;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] threshold;
        logic [2:0]  comparator;
        logic [31:0] priority_val;
        logic        enable;
        logic [31:0] best_priority;
        logic        best_found;
    } cmp_in_t;

endpackage

// ===== sv/priority_threshold_rule_selector_top.sv =====
`timescale 1ns / 1ps
// Channel  | Group          | tdata fields, lowest bit first
// ---------+----------------+---------------------------------------------------
// command  | s_axis_* (in)  | command, metric_id, comparator, threshold,
//          |                | target_id, priority_req, dis_slot, metric_value
// result   | m_axis_* (out) | status, slot_or_match, matched, switched,
//          |                | from_target, to_target, metric_readback
//
// Add, disable, write and read pass from idle to the response state and back to idle.
// Evaluate reads one rule slot a cycle from the rule RAM through one shared compare
// unit, with pipeline fill and drain; on an empty table it goes straight to the response.
// Reset empties the rule table, zeroes all metrics and clears the target.
// A stalled result sits in the output register; the next beat is still taken.
module priority_threshold_rule_selector_top
    import ptrs_pkg::*;
#(
    parameter int RULE_SLOTS   = DEF_RULE_SLOTS,
    parameter int METRIC_COUNT = DEF_METRIC_COUNT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command, metric_id, comparator, threshold, target_id, priority_req,
    // dis_slot, metric_value, zero fill
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, slot_or_match, matched, switched, from_target, to_target,
    // metric_readback, zero fill
    output logic [55:0]  m_axis_tdata
);

    localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
    localparam int MET_W  = (METRIC_COUNT > 1) ? $clog2(METRIC_COUNT) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    typedef struct packed {
        logic [31:0] metric_readback;
        logic [7:0]  to_target;
        logic [7:0]  from_target;
        logic        switched;
        logic        matched;
        logic [3:0]  slot_or_match;
        logic        status;
    } res_t;

    logic [2:0]  in_command;
    logic [2:0]  in_metric_id;
    logic [2:0]  in_comparator;
    logic [31:0] in_threshold;
    logic [7:0]  in_target_id;
    logic [31:0] in_priority_req;
    logic [3:0]  in_dis_slot;
    logic [31:0] in_metric_value;

    assign in_command      = s_axis_tdata[2:0];
    assign in_metric_id    = s_axis_tdata[5:3];
    assign in_comparator   = s_axis_tdata[8:6];
    assign in_threshold    = s_axis_tdata[40:9];
    assign in_target_id    = s_axis_tdata[48:41];
    assign in_priority_req = s_axis_tdata[80:49];
    assign in_dis_slot     = s_axis_tdata[84:81];
    assign in_metric_value = s_axis_tdata[116:85];

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [7:0]        active_reg, active_next;
    logic              issuing_reg, issuing_next;
    logic [SLOT_W-1:0] iss_idx_reg, iss_idx_next;
    logic              q_vld_reg, q_vld_next;
    logic [SLOT_W-1:0] q_idx_reg;
    logic              s1_vld_reg, s1_vld_next;
    logic [31:0]       s1_value_reg;
    rule_ent_t         s1_ent_reg;
    logic              s1_en_reg;
    logic [SLOT_W-1:0] s1_idx_reg;
    logic              best_found_reg, best_found_next;
    logic [31:0]       best_pri_reg, best_pri_next;
    logic [SLOT_W-1:0] best_idx_reg, best_idx_next;
    logic [7:0]        best_tgt_reg, best_tgt_next;
    res_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    res_t              m_data_reg, m_data_next;

    logic              en_reg [RULE_SLOTS];
    logic [31:0]       metric_reg [METRIC_COUNT];

    logic              accept;
    logic              add_ok;
    logic              dis_ok;
    logic              met_wr;
    rule_ent_t         ram_wdata;
    rule_ent_t         ram_q;
    logic [2:0]        met_sel;
    logic [31:0]       met_rd;
    cmp_in_t           cin;
    logic              take;
    logic              scan_done;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign add_ok        = (in_target_id != 8'd0) && (32'(used_reg) < RULE_SLOTS);
    assign dis_ok        = {28'd0, in_dis_slot} < 32'(used_reg);
    assign met_wr        = accept && (in_command == CMD_WRITE) &&
                           (32'(in_metric_id) < METRIC_COUNT);

    assign ram_wdata = '{priority_val: in_priority_req, threshold: in_threshold,
                         target: in_target_id, comparator: in_comparator,
                         metric: in_metric_id};

    ptrs_ram #(
        .WIDTH ($bits(rule_ent_t)),
        .DEPTH (RULE_SLOTS)
    ) u_rule_ram (
        .clk   (clk),
        .we    (accept && (in_command == CMD_ADD) && add_ok),
        .waddr (SLOT_W'(used_reg)),
        .wdata (ram_wdata),
        .raddr (iss_idx_reg),
        .rdata (ram_q)
    );

    assign met_sel = (state_reg == ST_IDLE) ? in_metric_id : ram_q.metric;
    assign met_rd  = (32'(met_sel) < METRIC_COUNT) ? metric_reg[MET_W'(met_sel)] : 32'd0;

    assign cin = '{value: s1_value_reg, threshold: s1_ent_reg.threshold,
                   comparator: s1_ent_reg.comparator,
                   priority_val: s1_ent_reg.priority_val, enable: s1_en_reg,
                   best_priority: best_pri_reg, best_found: best_found_reg};

    ptrs_cmp u_cmp (
        .cin  (cin),
        .take (take)
    );

    assign scan_done = !issuing_reg && !q_vld_reg && !s1_vld_reg;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        active_next     = active_reg;
        issuing_next    = issuing_reg;
        iss_idx_next    = iss_idx_reg;
        q_vld_next      = issuing_reg;
        s1_vld_next     = q_vld_reg;
        best_found_next = best_found_reg;
        best_pri_next   = best_pri_reg;
        best_idx_next   = best_idx_reg;
        best_tgt_next   = best_tgt_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;

        if (issuing_reg)
        begin
            if (32'(iss_idx_reg) + 32'd1 >= 32'(used_reg))
            begin
                issuing_next = 1'b0;
            end
            else
            begin
                iss_idx_next = iss_idx_reg + 1'b1;
            end
        end

        if (s1_vld_reg && take)
        begin
            best_found_next = 1'b1;
            best_pri_next   = s1_ent_reg.priority_val;
            best_idx_next   = s1_idx_reg;
            best_tgt_next   = s1_ent_reg.target;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = ST_RESP;
                    case (in_command)
                        CMD_ADD:
                        begin
                            if (add_ok)
                            begin
                                res_next.slot_or_match = 4'(used_reg);
                                used_next              = CNT_W'(used_reg + 1'b1);
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                        end
                        CMD_DISABLE:
                        begin
                            res_next.status = !dis_ok;
                        end
                        CMD_READ:
                        begin
                            res_next.metric_readback = met_rd;
                        end
                        CMD_EVAL:
                        begin
                            res_next.from_target = active_reg;
                            if (used_reg != '0)
                            begin
                                state_next      = ST_SCAN;
                                issuing_next    = 1'b1;
                                iss_idx_next    = '0;
                                best_found_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_RESP;
                    if (best_found_reg)
                    begin
                        res_next.matched       = 1'b1;
                        res_next.slot_or_match = 4'(best_idx_reg);
                        res_next.to_target     = best_tgt_reg;
                        res_next.switched      = best_tgt_reg != active_reg;
                        active_next            = best_tgt_reg;
                    end
                end
            end
            ST_RESP:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            active_reg     <= '0;
            issuing_reg    <= 1'b0;
            iss_idx_reg    <= '0;
            q_vld_reg      <= 1'b0;
            s1_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            active_reg     <= active_next;
            issuing_reg    <= issuing_next;
            iss_idx_reg    <= iss_idx_next;
            q_vld_reg      <= q_vld_next;
            s1_vld_reg     <= s1_vld_next;
            best_found_reg <= best_found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < METRIC_COUNT; i++)
            begin
                metric_reg[i] <= '0;
            end
        end
        else if (met_wr)
        begin
            metric_reg[MET_W'(in_metric_id)] <= in_metric_value;
        end
    end

    always_ff @(posedge clk)
    begin
        q_idx_reg    <= iss_idx_reg;
        s1_value_reg <= met_rd;
        s1_ent_reg   <= ram_q;
        s1_en_reg    <= en_reg[q_idx_reg];
        s1_idx_reg   <= q_idx_reg;
        best_pri_reg <= best_pri_next;
        best_idx_reg <= best_idx_next;
        best_tgt_reg <= best_tgt_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
        if (accept && (in_command == CMD_ADD) && add_ok)
        begin
            en_reg[SLOT_W'(used_reg)] <= 1'b1;
        end
        else if (accept && (in_command == CMD_DISABLE) && dis_ok)
        begin
            en_reg[SLOT_W'(in_dis_slot)] <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_data_reg};

endmodule

// ===== sv/ptrs_ram.sv =====
`timescale 1ns / 1ps
module ptrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ptrs_cmp.sv =====
`timescale 1ns / 1ps
module ptrs_cmp
    import ptrs_pkg::*;
(
    input  cmp_in_t cin,
    output logic    take
);

    logic v_lt_th;
    logic th_lt_v;
    logic v_eq_th;
    logic hit;
    logic better;

    assign v_lt_th = $signed(cin.value) < $signed(cin.threshold);
    assign th_lt_v = $signed(cin.threshold) < $signed(cin.value);
    assign v_eq_th = cin.value == cin.threshold;

    always_comb
    begin
        case (cin.comparator)
            CMP_LT:  hit = v_lt_th;
            CMP_LE:  hit = !th_lt_v;
            CMP_GT:  hit = th_lt_v;
            CMP_GE:  hit = !v_lt_th;
            CMP_EQ:  hit = v_eq_th;
            CMP_NE:  hit = !v_eq_th;
            default: hit = 1'b0;
        endcase
    end

    assign better = !cin.best_found ||
                    ($signed(cin.best_priority) < $signed(cin.priority_val));
    assign take   = cin.enable && hit && better;

endmodule

// ===== sv/ptrs_chk.sv =====
`timescale 1ns / 1ps
module ptrs_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata
);

    logic [54:0] out_beat;

    assign out_beat = m_axis_tdata[54:0];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command taken while one is in flight");

    a_switch_sense: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_beat[6] |->
            out_beat[5] && (out_beat[22:15] != out_beat[14:7]) &&
            (out_beat[22:15] != 8'd0))
        else $error("switch reported without a fresh matched target");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_beat[0] |-> (out_beat[54:1] == 54'd0))
        else $error("rejected result carries data");

endmodule

bind priority_threshold_rule_selector_top ptrs_chk u_ptrs_chk (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import ptrs_pkg::*;

    localparam int SLOTS        = DEF_RULE_SLOTS;
    localparam int METRICS      = DEF_METRIC_COUNT;
    localparam int RANDOM_BEATS = 1500;
    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [2:0] CMP_RSVD7 = 3'd7;

    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [31:0] metric_value;
        logic [3:0]         dis_slot;
        logic signed [31:0] priority_req;
        logic [7:0]         target_id;
        logic signed [31:0] threshold;
        logic [2:0]         comparator;
        logic [2:0]         metric_id;
        logic [2:0]         command;
    } cmd_beat_t;

    typedef struct packed {
        logic signed [31:0] readback;
        logic [7:0]         to_target;
        logic [7:0]         from_target;
        logic               switched;
        logic               matched;
        logic [3:0]         slot;
        logic               status;
    } verdict_t;

    typedef struct {
        logic signed [31:0] threshold;
        logic signed [31:0] prio;
        logic [2:0]         metric;
        logic [2:0]         comparator;
        logic [7:0]         target;
        logic               enabled;
    } rule_t;

    typedef struct {
        cmd_beat_t beat;
        bit        known;
        verdict_t  want;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;

    rule_t              rule_tab[SLOTS];
    int                 rules_held;
    logic signed [31:0] metric_regs[METRICS];
    logic [7:0]         current_target;

    verdict_t pending_results[$];
    dir_row_t dir_rows[$];

    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int hold_request  = 0;
    int mismatch_count = 0;
    int quiet_cycles  = 0;

    priority_threshold_rule_selector_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit rule_fires(logic signed [31:0] v, logic [2:0] cmp,
                                      logic signed [31:0] th);
        case (cmp)
            CMP_LT:  return v < th;
            CMP_LE:  return v <= th;
            CMP_GT:  return v > th;
            CMP_GE:  return v >= th;
            CMP_EQ:  return v == th;
            CMP_NE:  return v != th;
            default: return 1'b0;
        endcase
    endfunction

    function automatic verdict_t apply_command(cmd_beat_t c);
        verdict_t           r;
        logic signed [31:0] v;
        int                 best;
        bit                 found;
        r     = '0;
        best  = 0;
        found = 1'b0;
        case (c.command)
            CMD_ADD:
            begin
                if (c.target_id == 8'd0 || rules_held >= SLOTS)
                    r.status = 1'b1;
                else
                begin
                    rule_tab[rules_held] = '{c.threshold, c.priority_req, c.metric_id,
                                             c.comparator, c.target_id, 1'b1};
                    r.slot = 4'(rules_held);
                    rules_held++;
                end
            end
            CMD_DISABLE:
            begin
                if (int'(c.dis_slot) >= rules_held)
                    r.status = 1'b1;
                else
                    rule_tab[c.dis_slot].enabled = 1'b0;
            end
            CMD_WRITE:
            begin
                if (c.metric_id < METRICS)
                    metric_regs[c.metric_id] = c.metric_value;
            end
            CMD_READ:
            begin
                if (c.metric_id < METRICS)
                    r.readback = metric_regs[c.metric_id];
            end
            CMD_EVAL:
            begin
                r.from_target = current_target;
                for (int i = 0; i < rules_held; i++)
                begin
                    v = (rule_tab[i].metric < METRICS) ? metric_regs[rule_tab[i].metric] : '0;
                    if (rule_tab[i].enabled
                        && rule_fires(v, rule_tab[i].comparator, rule_tab[i].threshold)
                        && (!found || rule_tab[i].prio > rule_tab[best].prio))
                    begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    r.matched   = 1'b1;
                    r.slot      = 4'(best);
                    r.to_target = rule_tab[best].target;
                    if (r.to_target != current_target)
                    begin
                        r.switched     = 1'b1;
                        current_target = r.to_target;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic cmd_beat_t mk_beat(logic [2:0] cmd, logic [2:0] metric,
                                          logic [2:0] cmp, logic signed [31:0] th,
                                          logic [7:0] tgt, logic signed [31:0] prio,
                                          logic [3:0] idx, logic signed [31:0] val);
        cmd_beat_t b;
        b.command      = cmd;
        b.metric_id    = metric;
        b.comparator   = cmp;
        b.threshold    = th;
        b.target_id    = tgt;
        b.priority_req = prio;
        b.dis_slot     = idx;
        b.metric_value = val;
        return b;
    endfunction

    function automatic verdict_t mk_verdict(int st, int slot, int hit, int sw, int from_t,
                                            int to_t, logic signed [31:0] rb);
        verdict_t r;
        r.status      = 1'(st);
        r.slot        = 4'(slot);
        r.matched     = 1'(hit);
        r.switched    = 1'(sw);
        r.from_target = 8'(from_t);
        r.to_target   = 8'(to_t);
        r.readback    = rb;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_word();
        int k;
        case ($urandom_range(9))
            0, 1, 2, 3, 4:
            begin
                k = int'($urandom_range(4)) - 2;
                return k;
            end
            5:       return S32_MIN;
            6:       return S32_MAX;
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_beat_t random_beat();
        cmd_beat_t    b;
        logic [127:0] noise;
        int           roll;
        int           small_prio;
        noise        = {$urandom, $urandom, $urandom, $urandom};
        b            = noise[116:0];
        b.metric_id  = ($urandom_range(9) == 0) ? 3'($urandom_range(7, METRICS))
                                                : 3'($urandom_range(METRICS - 1));
        b.comparator = 3'($urandom_range(7));
        roll         = $urandom_range(99);
        if (roll < 12)
        begin
            b.command   = CMD_ADD;
            b.threshold = pick_word();
            b.target_id = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
            small_prio  = int'($urandom_range(6)) - 3;
            b.priority_req = $urandom_range(1) ? pick_word() : small_prio;
        end
        else if (roll < 14)
            b.command = CMD_DISABLE;
        else if (roll < 50)
        begin
            b.command      = CMD_WRITE;
            b.metric_value = pick_word();
        end
        else if (roll < 60)
            b.command = CMD_READ;
        else if (roll < 63)
            b.command = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
        else
            b.command = CMD_EVAL;
        return b;
    endfunction

    task automatic report(string what, verdict_t want, verdict_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t %s: exp st=%0d slot=%0d m=%0d sw=%0d from=%0d to=%0d rb=%0d",
                     $realtime, what, want.status, want.slot, want.matched, want.switched,
                     want.from_target, want.to_target, want.readback);
            $display("%0t %s: got st=%0d slot=%0d m=%0d sw=%0d from=%0d to=%0d rb=%0d",
                     $realtime, what, got.status, got.slot, got.matched, got.switched,
                     got.from_target, got.to_target, got.readback);
        end
    endtask

    // enter and leave at a falling edge
    task automatic send_beat(cmd_beat_t b, bit known, verdict_t want);
        verdict_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = apply_command(b);
        pending_results.push_back(known ? want : predicted);
        @(negedge clk);
    endtask

    initial
    begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[54:0];
            if (pending_results.size() == 0)
                report("unexpected beat", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.slot !== want.slot
                    || got.matched !== want.matched || got.switched !== want.switched
                    || got.from_target !== want.from_target
                    || got.to_target !== want.to_target || got.readback !== want.readback)
                    report("mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        rules_held     = 0;
        current_target = 8'd0;
        foreach (metric_regs[k])
            metric_regs[k] = '0;

        dir_rows.push_back('{mk_beat(CMD_READ, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd0, 0), 1'b1,
                             mk_verdict(0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_beat(CMD_EVAL, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd0, 0), 1'b1,
                             mk_verdict(0, 0, 0, 0, 0, 0, 0)});
        // empty target
        dir_rows.push_back('{mk_beat(CMD_ADD, 3'd1, CMP_LT, 0, 8'd0, 0, 4'd0, 0), 1'b1,
                             mk_verdict(1, 0, 0, 0, 0, 0, 0)});
        // slot never used
        dir_rows.push_back('{mk_beat(CMD_DISABLE, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd15, 0), 1'b1,
                             mk_verdict(1, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_beat(CMD_WRITE, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd0, S32_MIN),
                             1'b1, mk_verdict(0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_beat(CMD_WRITE, 3'd5, CMP_LT, 0, 8'd0, 0, 4'd0, S32_MAX),
                             1'b1, mk_verdict(0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_beat(CMD_READ, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd0, 0), 1'b1,
                             mk_verdict(0, 0, 0, 0, 0, 0, S32_MIN)});
        dir_rows.push_back('{mk_beat(CMD_READ, 3'd5, CMP_LT, 0, 8'd0, 0, 4'd0, 0), 1'b1,
                             mk_verdict(0, 0, 0, 0, 0, 0, S32_MAX)});
        dir_rows.push_back('{mk_beat(CMD_ADD, 3'd0, CMP_LT, S32_MAX, 8'd255, S32_MIN, 4'd0, 0),
                             1'b1, mk_verdict(0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_beat(CMD_ADD, 3'd5, CMP_GE, S32_MAX, 8'd1, S32_MAX, 4'd0, 0),
                             1'b1, mk_verdict(0, 1, 0, 0, 0, 0, 0)});
        // reserved comparator: stored, never fires
        dir_rows.push_back('{mk_beat(CMD_ADD, 3'd1, CMP_RSVD7, 0, 8'd2, S32_MAX, 4'd0, 0),
                             1'b1, mk_verdict(0, 2, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_beat(CMD_ADD, 3'd2, CMP_EQ, 0, 8'd3, S32_MAX, 4'd0, 0),
                             1'b1, mk_verdict(0, 3, 0, 0, 0, 0, 0)});
        // tie on priority: lower slot wins
        dir_rows.push_back('{mk_beat(CMD_EVAL, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd0, 0), 1'b0, '0});
        // match on the active target
        dir_rows.push_back('{mk_beat(CMD_EVAL, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_beat(CMD_DISABLE, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd1, 0), 1'b0, '0});
        // disable an already disabled rule
        dir_rows.push_back('{mk_beat(CMD_DISABLE, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd1, 0), 1'b0, '0});
        dir_rows.push_back('{mk_beat(CMD_EVAL, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_beat(CMD_ADD, 3'd4, CMP_NE, 5, 8'd4, 100, 4'd0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_beat(CMD_ADD, 3'd1, CMP_LE, -1, 8'd5, 0, 4'd0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_beat(CMD_ADD, 3'd1, CMP_GT, 0, 8'd6, 1, 4'd0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_beat(CMD_WRITE, 3'd2, CMP_LT, 0, 8'd0, 0, 4'd0, 1), 1'b0, '0});
        dir_rows.push_back('{mk_beat(CMD_EVAL, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_beat(CMD_WRITE, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd0, S32_MAX),
                             1'b0, '0});
        dir_rows.push_back('{mk_beat(CMD_WRITE, 3'd4, CMP_LT, 0, 8'd0, 0, 4'd0, 5), 1'b0, '0});
        // nothing fires: active target kept
        dir_rows.push_back('{mk_beat(CMD_EVAL, 3'd0, CMP_LT, 0, 8'd0, 0, 4'd0, 0), 1'b0, '0});
        // unknown command: every field zero
        dir_rows.push_back('{mk_beat(CMD_RSVD_HI, 3'd2, CMP_GT, 7, 8'd9, 3, 4'd3, 11), 1'b1,
                             mk_verdict(0, 0, 0, 0, 0, 0, 0)});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct = 30;
        snk_idle_pct = 57;
        foreach (dir_rows[k])
            send_beat(dir_rows[k].beat, dir_rows[k].known, dir_rows[k].want);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 3)
            begin
                src_idle_pct = 57;
                snk_idle_pct = 30;
            end
            if (n == 2 * RANDOM_BEATS / 3)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            // hold the result side off to back the block up
            if (n == 100 || n == 2 * RANDOM_BEATS / 3 + 50)
                hold_request = LONG_HOLD;
            send_beat(random_beat(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ptrs_pkg.sv
sv/ptrs_ram.sv
sv/ptrs_cmp.sv
sv/priority_threshold_rule_selector_top.sv
sv/ptrs_chk.sv
dv/tb.sv
